// ===== design/tfvn_pkg.sv =====
// shared types and constants for the tileable fractal value noise texel block
// no dependencies; used by the octave cell, the divider cell and the top level
package tfvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int COORD_BITS_DEF  = 12;

    localparam int SUM_W   = 17;
    localparam int ALPHA_W = 16;
    localparam int REM_W   = 33;
    localparam int IDX_W   = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TILE_SIZE_LOG2 = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOWEST_OCTAVE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGHEST_OCTAVE = 3'd2;
    localparam logic [IDX_W-1:0] REG_RAMP_LOW       = 3'd3;
    localparam logic [IDX_W-1:0] REG_RAMP_HIGH      = 3'd4;

    localparam logic [3:0]       TILE_LOG2_RST = 4'd10;
    localparam logic [2:0]       LOW_OCT_RST   = 3'd2;
    localparam logic [2:0]       HIGH_OCT_RST  = 3'd6;
    localparam logic [SUM_W-1:0] RAMP_LOW_RST  = 17'd72090;
    localparam logic [SUM_W-1:0] RAMP_HIGH_RST = 17'd91750;

    // lattice hash constants
    localparam logic [31:0] HASH_KX   = 32'd1619;
    localparam logic [31:0] HASH_KY   = 32'd31337;
    localparam logic [31:0] HASH_M31  = 32'h7fffffff;
    localparam logic [31:0] HASH_K2   = 32'd60493;
    localparam logic [31:0] HASH_K1   = 32'd19990303;
    localparam logic [31:0] HASH_K0   = 32'd1376312589;

    typedef struct packed {
        logic [3:0] tile_log2;
        logic [2:0] lo;
        logic [2:0] hi;
    } oct_cfg_t;

    typedef enum logic [1:0] {
        AM_ZERO,
        AM_FULL,
        AM_DIV
    } alpha_mode_t;

    typedef struct packed {
        logic             valid;
        alpha_mode_t      mode;
        logic [SUM_W-1:0] sum;
    } div_ctl_t;

endpackage

// ===== design/tfvn_octave_cell.sv =====
// one octave cell: hashes the four lattice corners, blends them and adds
// the weighted octave value to the running sum; depends on tfvn_pkg
module tfvn_octave_cell #(
    parameter int K  = 0,
    parameter int CB = tfvn_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  tfvn_pkg::oct_cfg_t          cfg,
    input  logic                        in_valid,
    input  logic [CB-1:0]               in_x,
    input  logic [CB-1:0]               in_y,
    input  logic [tfvn_pkg::SUM_W-1:0]  in_sum,
    output logic                        out_valid,
    output logic [CB-1:0]               out_x,
    output logic [CB-1:0]               out_y,
    output logic [tfvn_pkg::SUM_W-1:0]  out_sum
);

    localparam int IW = CB + 1;
    localparam int FW = K + 1;
    localparam int LW = 16 + FW;
    localparam int BW = 16 + 2 * FW;
    localparam int D  = 8;
    localparam logic [FW-1:0] CELL = FW'(1 << K);
    localparam logic [15:0]   FMASK = 16'((1 << K) - 1);

    logic                       v_reg   [D];
    logic [CB-1:0]              x_reg   [D];
    logic [CB-1:0]              y_reg   [D];
    logic [tfvn_pkg::SUM_W-1:0] sum_reg [D];
    logic [FW-1:0]              fx_reg  [D-1];
    logic [FW-1:0]              fy_reg  [D-1];

    logic [IW-1:0] ix_reg [4];
    logic [IW-1:0] iy_reg [4];
    logic [31:0]   n_reg  [4];
    logic [31:0]   sq_reg [4];
    logic [31:0]   na_reg [4];
    logic [31:0]   t_reg  [4];
    logic [31:0]   nb_reg [4];
    logic [31:0]   p_reg  [4];
    logic [LW-1:0] left_reg;
    logic [LW-1:0] right_reg;
    logic [15:0]   oct_reg;

    logic [IW-1:0] ix_next [4];
    logic [IW-1:0] iy_next [4];
    logic [31:0]   n_next  [4];
    logic [31:0]   sq_next [4];
    logic [31:0]   t_next  [4];
    logic [31:0]   p_next  [4];
    logic [LW-1:0] left_next;
    logic [LW-1:0] right_next;
    logic [15:0]   oct_next;
    logic [tfvn_pkg::SUM_W-1:0] sum_next;

    logic [CB-1:0] cx, cy;
    logic [16:0]   mask;
    logic [IW-1:0] x0, x1, y0, y1;
    logic [FW-1:0] fx_in, fy_in;
    logic [31:0]   n_raw [4];
    logic [31:0]   n_m   [4];
    logic [15:0]   cv    [4];
    logic [BW-1:0] blend;
    logic [15:0]   contrib;
    logic          oct_on;

    function automatic logic [31:0] HASH_KX_f(input logic [IW-1:0] ix);
        return tfvn_pkg::HASH_KX * 32'(ix);
    endfunction

    // corner order: c00, c10, c11, c01
    always_comb
    begin
        cx    = in_x >> K;
        cy    = in_y >> K;
        mask  = (cfg.tile_log2 < 4'(K)) ? 17'd0 : ((17'd1 << cfg.tile_log2) >> K) - 17'd1;
        x0    = IW'(cx) & mask[IW-1:0];
        x1    = (IW'(cx) + IW'(1)) & mask[IW-1:0];
        y0    = IW'(cy) & mask[IW-1:0];
        y1    = (IW'(cy) + IW'(1)) & mask[IW-1:0];
        fx_in = FW'(16'(in_x) & FMASK);
        fy_in = FW'(16'(in_y) & FMASK);
        ix_next[0] = x0;  iy_next[0] = y0;
        ix_next[1] = x1;  iy_next[1] = y0;
        ix_next[2] = x1;  iy_next[2] = y1;
        ix_next[3] = x0;  iy_next[3] = y1;
        for (int c = 0; c < 4; c++)
        begin
            n_raw[c]   = HASH_KX_f(ix_reg[c]) + tfvn_pkg::HASH_KY * 32'(iy_reg[c]);
            n_m[c]     = n_raw[c] & tfvn_pkg::HASH_M31;
            n_next[c]  = n_m[c] ^ (n_m[c] >> 13);
            sq_next[c] = n_reg[c] * n_reg[c];
            t_next[c]  = sq_reg[c] * tfvn_pkg::HASH_K2 + tfvn_pkg::HASH_K1;
            p_next[c]  = nb_reg[c] * t_reg[c] + tfvn_pkg::HASH_K0;
            cv[c]      = p_reg[c][30:15];
        end
        left_next  = LW'(fy_reg[4]) * LW'(cv[3]) + LW'(CELL - fy_reg[4]) * LW'(cv[0]);
        right_next = LW'(fy_reg[4]) * LW'(cv[2]) + LW'(CELL - fy_reg[4]) * LW'(cv[1]);
        blend      = BW'(right_reg) * BW'(fx_reg[5]) + BW'(left_reg) * BW'(CELL - fx_reg[5]);
        oct_next   = 16'(blend >> (2 * K));
        oct_on     = (cfg.lo <= 3'(K)) && (3'(K) <= cfg.hi);
        contrib    = oct_reg >> (cfg.hi - 3'(K));
        sum_next   = sum_reg[6] + (oct_on ? tfvn_pkg::SUM_W'(contrib) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < D; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < D; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= in_x;
            y_reg[0]   <= in_y;
            sum_reg[0] <= in_sum;
            fx_reg[0]  <= fx_in;
            fy_reg[0]  <= fy_in;
            for (int s = 1; s < D; s++)
            begin
                x_reg[s] <= x_reg[s-1];
                y_reg[s] <= y_reg[s-1];
            end
            for (int s = 1; s < D - 1; s++)
            begin
                sum_reg[s] <= sum_reg[s-1];
                fx_reg[s]  <= fx_reg[s-1];
                fy_reg[s]  <= fy_reg[s-1];
            end
            sum_reg[D-1] <= sum_next;
            for (int c = 0; c < 4; c++)
            begin
                ix_reg[c] <= ix_next[c];
                iy_reg[c] <= iy_next[c];
                n_reg[c]  <= n_next[c];
                sq_reg[c] <= sq_next[c];
                na_reg[c] <= n_reg[c];
                t_reg[c]  <= t_next[c];
                nb_reg[c] <= na_reg[c];
                p_reg[c]  <= p_next[c];
            end
            left_reg  <= left_next;
            right_reg <= right_next;
            oct_reg   <= oct_next;
        end
    end

    assign out_valid = v_reg[D-1];
    assign out_x     = x_reg[D-1];
    assign out_y     = y_reg[D-1];
    assign out_sum   = sum_reg[D-1];

endmodule

// ===== design/tfvn_div_cell.sv =====
// one restoring divider cell: settles quotient bit B of the alpha ramp
// depends on tfvn_pkg
module tfvn_div_cell #(
    parameter int B = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  tfvn_pkg::div_ctl_t            in_ctl,
    input  logic [tfvn_pkg::REM_W-1:0]    in_rem,
    input  logic [tfvn_pkg::SUM_W-1:0]    in_den,
    input  logic [tfvn_pkg::ALPHA_W-1:0]  in_q,
    output tfvn_pkg::div_ctl_t            out_ctl,
    output logic [tfvn_pkg::REM_W-1:0]    out_rem,
    output logic [tfvn_pkg::SUM_W-1:0]    out_den,
    output logic [tfvn_pkg::ALPHA_W-1:0]  out_q
);

    tfvn_pkg::div_ctl_t             ctl_reg;
    logic [tfvn_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [tfvn_pkg::SUM_W-1:0]     den_reg;
    logic [tfvn_pkg::ALPHA_W-1:0]   q_reg, q_next;
    logic [tfvn_pkg::REM_W-1:0]     shifted;
    logic                           take;

    always_comb
    begin
        shifted  = tfvn_pkg::REM_W'(in_den) << B;
        take     = (in_rem >= shifted);
        rem_next = take ? (in_rem - shifted) : in_rem;
        q_next   = in_q;
        q_next[B] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            q_reg   <= q_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_rem = rem_reg;
    assign out_den = den_reg;
    assign out_q   = q_reg;

    // remainder stays below the divisor at this bit weight
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && ctl_reg.mode == tfvn_pkg::AM_DIV
        |-> rem_reg < (tfvn_pkg::REM_W'(den_reg) << B))
        else $error("divider remainder out of range");

    // lower quotient bits are still unsettled and must be zero
    a_q_low: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (q_reg & ((tfvn_pkg::ALPHA_W'(1) << B) - 1'b1)) == '0)
        else $error("divider quotient low bits set early");

endmodule

// ===== design/tileable_fractal_value_noise_texel.sv =====
// path: item accept, the octave cell chain, the ramp setup register, the divider row, result valid
// throughput: one item per cycle; each octave cell is an 8-stage pipe, the alpha
//   divider is one cell per quotient bit, and the whole pipe stalls only when the
//   output item is held
// reset: asynchronous, active low; registers take their documented reset values
//   and the pipe empties; no clearing pass
module tileable_fractal_value_noise_texel #(
    parameter int MAX_OCTAVES = tfvn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_BITS  = tfvn_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tfvn_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tfvn_pkg::SUM_W-1:0]    cfg_data,
    // texel coordinate items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [11:0]                   texel_x,
    input  logic [11:0]                   texel_y,
    // noise result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tfvn_pkg::SUM_W-1:0]    noise_sum,
    output logic [tfvn_pkg::ALPHA_W-1:0]  coverage_alpha
);

    localparam int CB = COORD_BITS;
    localparam int NB = tfvn_pkg::ALPHA_W;

    // configuration registers
    logic [3:0]                 tile_log2_reg;
    logic [2:0]                 lo_oct_reg;
    logic [2:0]                 hi_oct_reg;
    logic [tfvn_pkg::SUM_W-1:0] ramp_low_reg;
    logic [tfvn_pkg::SUM_W-1:0] ramp_high_reg;

    tfvn_pkg::oct_cfg_t oct_cfg;
    logic               en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_log2_reg <= tfvn_pkg::TILE_LOG2_RST;
            lo_oct_reg    <= tfvn_pkg::LOW_OCT_RST;
            hi_oct_reg    <= tfvn_pkg::HIGH_OCT_RST;
            ramp_low_reg  <= tfvn_pkg::RAMP_LOW_RST;
            ramp_high_reg <= tfvn_pkg::RAMP_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tfvn_pkg::REG_TILE_SIZE_LOG2: tile_log2_reg <= cfg_data[3:0];
                tfvn_pkg::REG_LOWEST_OCTAVE:  lo_oct_reg    <= cfg_data[2:0];
                tfvn_pkg::REG_HIGHEST_OCTAVE: hi_oct_reg    <= cfg_data[2:0];
                tfvn_pkg::REG_RAMP_LOW:       ramp_low_reg  <= cfg_data;
                tfvn_pkg::REG_RAMP_HIGH:      ramp_high_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // highest octave is clamped to the cells that exist
    always_comb
    begin
        oct_cfg.tile_log2 = tile_log2_reg;
        oct_cfg.lo        = lo_oct_reg;
        oct_cfg.hi        = (hi_oct_reg > 3'(MAX_OCTAVES - 1)) ? 3'(MAX_OCTAVES - 1)
                                                               : hi_oct_reg;
    end

    // single stall: the whole pipe advances unless the output item is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // chain of octave cells, one per lattice size, passing the running sum along
    logic                       ch_v   [MAX_OCTAVES+1];
    logic [CB-1:0]              ch_x   [MAX_OCTAVES+1];
    logic [CB-1:0]              ch_y   [MAX_OCTAVES+1];
    logic [tfvn_pkg::SUM_W-1:0] ch_sum [MAX_OCTAVES+1];
    logic [15:0]                tx_w, ty_w;

    assign tx_w      = 16'(texel_x);
    assign ty_w      = 16'(texel_y);
    assign ch_v[0]   = in_valid;
    assign ch_x[0]   = tx_w[CB-1:0];
    assign ch_y[0]   = ty_w[CB-1:0];
    assign ch_sum[0] = '0;

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        tfvn_octave_cell #(
            .K  (k),
            .CB (CB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (oct_cfg),
            .in_valid  (ch_v[k]),
            .in_x      (ch_x[k]),
            .in_y      (ch_y[k]),
            .in_sum    (ch_sum[k]),
            .out_valid (ch_v[k+1]),
            .out_x     (ch_x[k+1]),
            .out_y     (ch_y[k+1]),
            .out_sum   (ch_sum[k+1])
        );
    end

    // ramp setup: threshold tests, then numerator (sum - low) * 65535 as a shift
    // and subtract, divisor high - low
    tfvn_pkg::div_ctl_t          a0_ctl_reg, a0_ctl_next;
    logic [tfvn_pkg::REM_W-1:0]  a0_rem_reg, a0_rem_next;
    logic [tfvn_pkg::SUM_W-1:0]  a0_den_reg, a0_den_next;
    logic [tfvn_pkg::SUM_W-1:0]  ramp_d;
    logic [tfvn_pkg::SUM_W-1:0]  fin_sum;

    assign fin_sum = ch_sum[MAX_OCTAVES];

    always_comb
    begin
        ramp_d            = fin_sum - ramp_low_reg;
        a0_ctl_next.valid = ch_v[MAX_OCTAVES];
        a0_ctl_next.sum   = fin_sum;
        if (fin_sum <= ramp_low_reg)
        begin
            a0_ctl_next.mode = tfvn_pkg::AM_ZERO;
        end
        else if (fin_sum >= ramp_high_reg)
        begin
            a0_ctl_next.mode = tfvn_pkg::AM_FULL;
        end
        else
        begin
            a0_ctl_next.mode = tfvn_pkg::AM_DIV;
        end
        a0_rem_next = (tfvn_pkg::REM_W'(ramp_d) << NB) - tfvn_pkg::REM_W'(ramp_d);
        a0_den_next = ramp_high_reg - ramp_low_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_ctl_reg <= '0;
        end
        else if (en)
        begin
            a0_ctl_reg <= a0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_rem_reg <= a0_rem_next;
            a0_den_reg <= a0_den_next;
        end
    end

    // divider row, most significant quotient bit first; the last cell is the
    // output register
    tfvn_pkg::div_ctl_t            dv_ctl [NB+1];
    logic [tfvn_pkg::REM_W-1:0]    dv_rem [NB+1];
    logic [tfvn_pkg::SUM_W-1:0]    dv_den [NB+1];
    logic [tfvn_pkg::ALPHA_W-1:0]  dv_q   [NB+1];

    assign dv_ctl[0] = a0_ctl_reg;
    assign dv_rem[0] = a0_rem_reg;
    assign dv_den[0] = a0_den_reg;
    assign dv_q[0]   = '0;

    for (genvar i = 0; i < NB; i++)
    begin : g_div
        tfvn_div_cell #(
            .B (NB - 1 - i)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_ctl  (dv_ctl[i]),
            .in_rem  (dv_rem[i]),
            .in_den  (dv_den[i]),
            .in_q    (dv_q[i]),
            .out_ctl (dv_ctl[i+1]),
            .out_rem (dv_rem[i+1]),
            .out_den (dv_den[i+1]),
            .out_q   (dv_q[i+1])
        );
    end

    // result item
    assign out_valid = dv_ctl[NB].valid;
    assign noise_sum = dv_ctl[NB].sum;

    always_comb
    begin
        case (dv_ctl[NB].mode)
            tfvn_pkg::AM_ZERO: coverage_alpha = '0;
            tfvn_pkg::AM_FULL: coverage_alpha = '1;
            tfvn_pkg::AM_DIV:  coverage_alpha = dv_q[NB];
            default:           coverage_alpha = '0;
        endcase
    end

    // alpha is zero at or below the low threshold
    a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && noise_sum <= ramp_low_reg |-> coverage_alpha == '0)
        else $error("alpha not zero below low threshold");

    // alpha saturates at or above the high threshold
    a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && noise_sum > ramp_low_reg && noise_sum >= ramp_high_reg
        |-> coverage_alpha == '1)
        else $error("alpha not saturated above high threshold");

    // octave sum never reaches the top of its field
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> noise_sum <= 17'd131070)
        else $error("noise sum out of range");

    // a held output item freezes the whole pipe
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

// ===== tb/tileable_fractal_value_noise_texel_tb.sv =====
// testbench for the tileable fractal value noise texel block
// self-checking: queue-fed driver, clocked monitor, in-bench predictor
// depends on tfvn_pkg and tileable_fractal_value_noise_texel
`timescale 1ns / 1ps

module tileable_fractal_value_noise_texel_tb;
    import tfvn_pkg::*;

    localparam int LATENCY     = 8 * MAX_OCTAVES_DEF + 17;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
    } texel_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [ALPHA_W-1:0] alpha;
    } noise_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [SUM_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [11:0] texel_x;
    logic [11:0] texel_y;
    logic out_valid;
    logic out_ready;
    logic [SUM_W-1:0] noise_sum;
    logic [ALPHA_W-1:0] coverage_alpha;

    // predictor copy of the registers
    logic [3:0]       p_tile_log2;
    logic [2:0]       p_lo;
    logic [2:0]       p_hi;
    logic [SUM_W-1:0] p_ramp_low;
    logic [SUM_W-1:0] p_ramp_high;

    texel_t pending_texels[$];
    noise_t expected_noise[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     steady;      // when set, neither side idles
    bit     hold_sender; // pressure pause

    tileable_fractal_value_noise_texel DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .texel_x(texel_x), .texel_y(texel_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .noise_sum(noise_sum), .coverage_alpha(coverage_alpha)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // 16-bit lattice hash, seed zero
    function automatic logic [31:0] lattice_hash(logic [31:0] ix, logic [31:0] iy);
        logic [31:0] n;
        n = (HASH_KX * ix + HASH_KY * iy) & HASH_M31;
        n = (n >> 13) ^ n;
        n = n * (n * n * HASH_K2 + HASH_K1) + HASH_K0;
        return (n & HASH_M31) >> 15;
    endfunction

    // bilinear value for one octave, 0..65535
    function automatic logic [31:0] octave_noise(logic [31:0] x, logic [31:0] y, int k);
        logic [31:0] cell_sz, mask, cx, cy, x0, x1, y0, y1;
        logic [31:0] c00, c10, c11, c01, fx, fy, left, right;
        cell_sz = 32'd1 << k;
        cx = x >> k;
        cy = y >> k;
        // tile smaller than a cell collapses onto corner (0, 0)
        mask = (p_tile_log2 < k) ? 32'd0 : (((32'd1 << p_tile_log2) >> k) - 32'd1);
        x0 = cx & mask;
        x1 = (cx + 1) & mask;
        y0 = cy & mask;
        y1 = (cy + 1) & mask;
        c00 = lattice_hash(x0, y0);
        c10 = lattice_hash(x1, y0);
        c11 = lattice_hash(x1, y1);
        c01 = lattice_hash(x0, y1);
        fx = x - (cx << k);
        fy = y - (cy << k);
        left  = fy * c01 + (cell_sz - fy) * c00;
        right = fy * c11 + (cell_sz - fy) * c10;
        return (right * fx + left * (cell_sz - fx)) >> (k + k);
    endfunction

    function automatic noise_t texel_noise(texel_t t);
        noise_t r;
        logic [31:0] sum;
        logic [63:0] quot;
        int hi;
        sum = 0;
        hi = (p_hi > MAX_OCTAVES_DEF - 1) ? MAX_OCTAVES_DEF - 1 : p_hi;
        // an empty octave range leaves the sum at zero
        for (int k = p_lo; k <= hi; k++)
            sum += octave_noise({20'd0, t.x}, {20'd0, t.y}, k) >> (hi - k);
        // low threshold wins over high when out of order
        if (sum <= p_ramp_low)
            r.alpha = '0;
        else if (sum >= p_ramp_high)
            r.alpha = 16'hffff;
        else
        begin
            quot = (64'(sum - p_ramp_low) * 64'd65535) / 64'(p_ramp_high - p_ramp_low);
            r.alpha = quot[15:0];
        end
        r.sum = sum[SUM_W-1:0];
        return r;
    endfunction

    // register write between phases; the block is idle here
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TILE_SIZE_LOG2: p_tile_log2 = val[3:0];
            REG_LOWEST_OCTAVE:  p_lo        = val[2:0];
            REG_HIGHEST_OCTAVE: p_hi        = val[2:0];
            REG_RAMP_LOW:       p_ramp_low  = val;
            REG_RAMP_HIGH:      p_ramp_high = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_texels.size() == 0 && !in_valid);
        wait (expected_noise.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int tl, int lo, int hi, int rl, int rh);
        drain();
        write_reg(REG_TILE_SIZE_LOG2, SUM_W'(tl));
        write_reg(REG_LOWEST_OCTAVE, SUM_W'(lo));
        write_reg(REG_HIGHEST_OCTAVE, SUM_W'(hi));
        write_reg(REG_RAMP_LOW, SUM_W'(rl));
        write_reg(REG_RAMP_HIGH, SUM_W'(rh));
    endtask

    // mostly random texels, with a bias toward the tile corners
    function automatic texel_t random_texel();
        texel_t t;
        case ($urandom_range(0, 5))
            0: t = '{x: 12'hfff - $urandom_range(0, 3), y: $urandom_range(0, 3)};
            1: t = '{x: $urandom_range(0, 3), y: 12'hfff - $urandom_range(0, 3)};
            default: t = '{x: $urandom, y: $urandom};
        endcase
        return t;
    endfunction

    // driver: takes the next item from the queue, holds it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            texel_x  <= '0;
            texel_y  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                expected_noise.push_back(texel_noise('{x: texel_x, y: texel_y}));
            if (pending_texels.size() != 0 && !hold_sender
                && (steady || $urandom_range(0, 99) >= 18))
            begin
                texel_t t;
                t = pending_texels.pop_front();
                in_valid <= 1'b1;
                texel_x  <= t.x;
                texel_y  <= t.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each result item against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_noise.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: sum %0d alpha %0d", noise_sum, coverage_alpha);
                end
                else
                begin
                    noise_t e;
                    e = expected_noise.pop_front();
                    if (noise_sum !== e.sum || coverage_alpha !== e.alpha)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: sum exp %0d got %0d, alpha exp %0d got %0d",
                                     e.sum, noise_sum, e.alpha, coverage_alpha);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 18);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        steady      = 1'b0;
        hold_sender = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        p_tile_log2 = TILE_LOG2_RST;
        p_lo        = LOW_OCT_RST;
        p_hi        = HIGH_OCT_RST;
        p_ramp_low  = RAMP_LOW_RST;
        p_ramp_high = RAMP_HIGH_RST;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at reset settings: coordinate extremes, bit patterns and a tile edge
        pending_texels.push_back('{x: 12'd0,    y: 12'd0});
        pending_texels.push_back('{x: 12'hfff,  y: 12'hfff});
        pending_texels.push_back('{x: 12'hfff,  y: 12'd0});
        pending_texels.push_back('{x: 12'd0,    y: 12'hfff});
        pending_texels.push_back('{x: 12'haaa,  y: 12'h555});
        pending_texels.push_back('{x: 12'h555,  y: 12'haaa});
        pending_texels.push_back('{x: 12'd1023, y: 12'd1024});

        // empty octave range gives a zero sum
        set_config(7, 5, 2, 0, 1);
        pending_texels.push_back('{x: 12'd77, y: 12'd300});
        // thresholds out of order, every octave, tile as large as the top octave cell
        set_config(7, 0, 7, 100, 50);
        pending_texels.push_back('{x: 12'hfff, y: 12'd3});
        pending_texels.push_back('{x: 12'd128, y: 12'd129});
        // large tile, alpha ramp over the full range
        set_config(12, 0, 7, 0, 131071);
        pending_texels.push_back('{x: 12'd4095, y: 12'd4095});
        pending_texels.push_back('{x: 12'd2048, y: 12'd17});
        // extreme thresholds with the largest and the smallest tile setting
        set_config(15, 7, 7, 131071, 131071);
        pending_texels.push_back('{x: 12'd300, y: 12'd4000});
        set_config(0, 0, 0, 0, 131071);
        pending_texels.push_back('{x: 12'd1, y: 12'd1});

        // random phases through several settings
        for (int phase = 0; phase < 8; phase++)
        begin
            set_config($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 131071), $urandom_range(0, 131071));
            if (phase % 3 == 0)
            begin
                // thresholds bracketing typical sums so alpha ramps
                write_reg(REG_RAMP_LOW, SUM_W'($urandom_range(0, 60000)));
                write_reg(REG_RAMP_HIGH, SUM_W'($urandom_range(60001, 131071)));
            end
            steady = (phase == 2);
            for (int i = 0; i < 230; i++)
                pending_texels.push_back(random_texel());
            if (phase == 4)
            begin
                // sender pauses until every outstanding item has come back
                wait (pending_texels.size() < 115);
                hold_sender = 1'b1;
                wait (expected_noise.size() == 0 && !in_valid);
                hold_sender = 1'b0;
            end
        end
        steady = 1'b0;

        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && expected_noise.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tfvn_pkg.sv
design/tfvn_octave_cell.sv
design/tfvn_div_cell.sv
design/tileable_fractal_value_noise_texel.sv
tb/tileable_fractal_value_noise_texel_tb.sv
